### rtl/pdfm_pkg.sv
`default_nettype none

package pdfm_pkg;

   // Default width of the free-running capture counter.
   localparam int COUNT_WIDTH_DEF = 16;
   // Entries in the queue between the capture front and the divider back.
   localparam int QUEUE_DEPTH_DEF = 4;

   // Field widths of the streams.
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 64;
   localparam int TICKS_WIDTH    = 16;
   localparam int DUTY_WIDTH     = 7;
   localparam int FREQ_WIDTH     = 23;
   localparam int RSP_PAD_WIDTH  = RSP_DATA_WIDTH - 2 * TICKS_WIDTH - DUTY_WIDTH - FREQ_WIDTH;

   // Tick rate register.
   localparam int                    RATE_WIDTH = 24;
   localparam logic [RATE_WIDTH-1:0] RATE_RESET = 24'd1000000;

   // Scale of the duty result.
   localparam int DUTY_SCALE = 100;

   // Capture sequence of the front.
   typedef enum logic [1:0] {
      PH_WAIT_RISE,
      PH_WAIT_FALL,
      PH_WAIT_SECOND
   } phase_type;

   // Sequence of the divider back.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DUTY,
      BK_FREQ,
      BK_DONE
   } back_state_type;

   // Fill status of the job queue.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

### rtl/pdfm_front.sv
`default_nettype none

module pdfm_front
   import pdfm_pkg::*;
#(
   parameter int CountWidth = COUNT_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,  // [0] signal_level
   input  wire qstat_type                 qstat,
   output logic                           push,
   output logic [2*CountWidth:0]          push_data   // {period, high, ok}
);

   phase_type              phase_ff, phase_in;
   logic                   prev_ff, prev_in;
   logic [CountWidth-1:0]  cnt_ff, cnt_in;
   logic [CountWidth-1:0]  first_ff, first_in;
   logic [CountWidth-1:0]  fall_ff, fall_in;

   logic                   take;
   logic                   level;
   logic                   rise;
   logic                   fall;
   logic                   job_ok;
   logic [CountWidth-1:0]  job_high;
   logic [CountWidth-1:0]  job_period;

   assign req_tready = !qstat.full;
   assign take       = req_tvalid && req_tready;
   assign level      = req_tdata[0];
   assign rise       = !prev_ff && level;
   assign fall       = prev_ff && !level;

   // Job fields for the tick that takes the second rising edge.
   assign job_ok     = (first_ff < fall_ff) && (fall_ff < cnt_ff);
   assign job_high   = fall_ff - first_ff;
   assign job_period = cnt_ff - first_ff;
   assign push_data  = {job_period, job_high, job_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_RISE;
         prev_ff  <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         cnt_ff   <= cnt_in;
      end
      first_ff <= first_in;
      fall_ff  <= fall_in;
   end

   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      fall_in  = fall_ff;
      push     = 1'b0;
      if (take) begin
         prev_in = level;
         cnt_in  = cnt_ff + 1'b1;
         case (phase_ff)
            PH_WAIT_RISE: begin
               if (rise) begin
                  first_in = cnt_ff;
                  phase_in = PH_WAIT_FALL;
               end
            end
            PH_WAIT_FALL: begin
               if (fall) begin
                  fall_in  = cnt_ff;
                  phase_in = PH_WAIT_SECOND;
               end
            end
            PH_WAIT_SECOND: begin
               if (rise) begin
                  push     = 1'b1;
                  phase_in = PH_WAIT_RISE;
               end
            end
            default: begin
               phase_in = PH_WAIT_RISE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/pdfm_queue.sv
`default_nettype none

module pdfm_queue
   import pdfm_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH_DEF,
   parameter int EntryWidth = 2 * COUNT_WIDTH_DEF + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [EntryWidth-1:0] push_data,
   input  wire logic                  pop,
   output logic      [EntryWidth-1:0] pop_data,
   output qstat_type                  qstat
);

   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   logic [EntryWidth-1:0] entry_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == CountWidth'(QueueDepth));
   assign qstat.empty = (count_ff == '0);
   assign pop_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("job popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

### rtl/pdfm_back.sv
`default_nettype none

module pdfm_back
   import pdfm_pkg::*;
#(
   parameter int CountWidth = COUNT_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [RATE_WIDTH-1:0]     rate_hz,
   input  wire qstat_type                 qstat,
   input  wire logic [2*CountWidth:0]     job_data,  // {period, high, ok}
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic                           rsp_tuser
);

   localparam int DivWidth  = (CountWidth + DUTY_WIDTH > RATE_WIDTH) ?
                              CountWidth + DUTY_WIDTH : RATE_WIDTH;
   localparam int StepWidth = $clog2(DivWidth);

   back_state_type              state_ff, state_in;
   logic [DivWidth-1:0]         num_ff, num_in;
   logic [CountWidth-1:0]       rem_ff, rem_in;
   logic [CountWidth-1:0]       den_ff, den_in;
   logic [StepWidth-1:0]        step_ff, step_in;
   logic                        ok_ff, ok_in;
   logic [TICKS_WIDTH-1:0]      high_ff, high_in;
   logic [TICKS_WIDTH-1:0]      period_ff, period_in;
   logic [DUTY_WIDTH-1:0]       duty_ff, duty_in;
   logic [FREQ_WIDTH-1:0]       freq_ff, freq_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic                        rsp_user_ff, rsp_user_in;

   logic                        job_ok;
   logic [CountWidth-1:0]       job_high;
   logic [CountWidth-1:0]       job_period;
   logic [DivWidth-1:0]         duty_num;
   logic [CountWidth:0]         rem_shift;
   logic [CountWidth:0]         rem_sub;
   logic                        take_bit;
   logic [CountWidth-1:0]       rem_next;
   logic [DivWidth-1:0]         num_next;
   logic                        last_step;
   logic                        out_free;

   assign job_ok     = job_data[0];
   assign job_high   = job_data[CountWidth:1];
   assign job_period = job_data[2*CountWidth:CountWidth+1];
   assign duty_num   = DivWidth'(job_high) * DivWidth'(DUTY_SCALE);

   // One restoring division step per cycle: quotient bits shift into num_ff.
   assign rem_shift = {rem_ff, num_ff[DivWidth-1]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign take_bit  = (rem_shift >= {1'b0, den_ff});
   assign rem_next  = take_bit ? rem_sub[CountWidth-1:0] : rem_shift[CountWidth-1:0];
   assign num_next  = {num_ff[DivWidth-2:0], take_bit};
   assign last_step = (step_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      step_ff     <= step_in;
      ok_ff       <= ok_in;
      high_ff     <= high_in;
      period_ff   <= period_in;
      duty_ff     <= duty_in;
      freq_ff     <= freq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      step_in      = step_ff;
      ok_in        = ok_ff;
      high_in      = high_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      freq_in      = freq_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               num_in = duty_num;
               rem_in = '0;
               den_in = job_period;
               step_in = StepWidth'(DivWidth - 1);
               ok_in  = job_ok;
               if (job_ok) begin
                  high_in   = TICKS_WIDTH'(job_high);
                  period_in = TICKS_WIDTH'(job_period);
                  state_in  = BK_DUTY;
               end else begin
                  high_in   = '0;
                  period_in = '0;
                  duty_in   = '0;
                  freq_in   = '0;
                  state_in  = BK_DONE;
               end
            end
         end
         BK_DUTY: begin
            num_in  = num_next;
            rem_in  = rem_next;
            step_in = step_ff - 1'b1;
            if (last_step) begin
               duty_in  = num_next[DUTY_WIDTH-1:0];
               num_in   = DivWidth'(rate_hz);
               rem_in   = '0;
               step_in  = StepWidth'(DivWidth - 1);
               state_in = BK_FREQ;
            end
         end
         BK_FREQ: begin
            num_in  = num_next;
            rem_in  = rem_next;
            step_in = step_ff - 1'b1;
            if (last_step) begin
               freq_in  = num_next[FREQ_WIDTH-1:0];
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = ok_ff;
               rsp_data_in  = {{RSP_PAD_WIDTH{1'b0}}, freq_ff, duty_ff, period_ff, high_ff};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DUTY || state_ff == BK_FREQ) |-> (rem_ff < den_ff))
      else $error("division remainder reached the divisor");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff == '0))
      else $error("invalid measurement carries nonzero data");

   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff[2*TICKS_WIDTH +: DUTY_WIDTH] <= DUTY_WIDTH'(DUTY_SCALE)))
      else $error("duty result above full scale");

endmodule

`default_nettype wire

### rtl/pwm_duty_frequency_meter_unit.sv
`default_nettype none

// PWM duty and frequency meter. Each req transaction is one tick of the
// capture timebase and carries the sampled signal level. An internal
// COUNT_WIDTH-bit tick counter advances on every accepted sample and wraps.
// The block captures the counter at a rising edge, the following falling
// edge and the next rising edge; on that third capture it queues one
// measurement and starts waiting for a fresh rising edge. Each measurement
// produces one rsp transaction: rsp_tuser is 1 when the three captures rose
// strictly and 0 when the counter wrapped in between, in which case every
// data field is zero. Duty is high*100/period and frequency is
// tick_rate_hz/period, both truncated. The front accepts one sample per
// clock as long as the measurement queue (QUEUE_DEPTH entries) has room.
// The back runs a shared one-bit-per-cycle restoring divider twice per
// measurement, once for duty and once for frequency, while an invalid
// measurement skips the divider; req_tready drops only while the queue is
// full, which happens when measurements complete faster than the back can
// divide and deliver them.
// tick_rate_hz resets to 1000000 and is written through the csr channel,
// which is always ready; write it only while no measurement is in flight.

module pwm_duty_frequency_meter_unit
   import pdfm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Sample stream.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,  // [0] signal_level, rest zero
   // Measurement stream.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,  // [15:0] high_ticks, [31:16] period_ticks,
                                                      // [38:32] duty_percent,
                                                      // [61:39] frequency_hz, rest zero
   output logic                           rsp_tuser,  // [0] valid_res
   // Tick rate register write.
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [RATE_WIDTH-1:0]     csr_wdata   // tick_rate_hz
);

   localparam int JobWidth = 2 * COUNT_WIDTH + 1;

   logic [RATE_WIDTH-1:0] rate_ff, rate_in;
   qstat_type             qstat;
   logic                  push;
   logic [JobWidth-1:0]   push_data;
   logic                  pop;
   logic [JobWidth-1:0]   pop_data;

   // The tick rate register takes every write transaction.
   assign csr_ready = 1'b1;
   assign rate_in   = (csr_valid && csr_ready) ? csr_wdata : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   // Edge detection and capture sequencing, one sample per clock while the queue has room.
   pdfm_front #(
      .CountWidth (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   // Completed capture triples waiting for the divider.
   pdfm_queue #(
      .QueueDepth (QUEUE_DEPTH),
      .EntryWidth (JobWidth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   // Duty and frequency division and the result register.
   pdfm_back #(
      .CountWidth (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .rate_hz    (rate_ff),
      .qstat      (qstat),
      .job_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### tb/sv/pwm_duty_frequency_meter_unit_test.sv
`timescale 1ns / 1ps

module pwm_duty_frequency_meter_unit_test;
   import pdfm_pkg::*;

   // One measurement as it leaves the block. The fields run from the most
   // significant bit down, so a concatenation in this order builds one.
   typedef struct packed {
      logic                   ok;
      logic [TICKS_WIDTH-1:0] high;
      logic [TICKS_WIDTH-1:0] period;
      logic [DUTY_WIDTH-1:0]  duty;
      logic [FREQ_WIDTH-1:0]  freq;
   } meas_type;

   // One row of the directed pulse train. Rows marked fixed carry a
   // measurement that is typed in by hand instead of being predicted.
   typedef struct packed {
      logic     level;
      bit       fixed;
      meas_type want;
   } pulse_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [RATE_WIDTH-1:0]     csr_wdata;

   // Own copy of the meter: tick counter, last sampled level, capture
   // sequence, the two stored stamps and the tick rate register.
   logic [TICKS_WIDTH-1:0] tick_now;
   logic                   last_level;
   phase_type              meter_phase;
   logic [TICKS_WIDTH-1:0] rise_stamp;
   logic [TICKS_WIDTH-1:0] fall_at;
   logic [RATE_WIDTH-1:0]  rate_hz;

   // Measurements that are owed by the block, oldest first.
   meas_type      pending_meas[$];
   pulse_row_type pulse_rows[$];

   // Random idling on each side can be switched off for a whole phase.
   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int errors = 0;

   pwm_duty_frequency_meter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advances the meter copy by one tick. A measurement comes out only on
   // the rising edge that closes the capture sequence. The stamps must rise
   // strictly; when the counter wrapped in between, the measurement is
   // invalid and every field stays zero. The closing edge never opens the
   // next sequence, a later rising edge has to do that.
   task automatic step_meter(input logic level, output bit got, output meas_type m);
      logic [TICKS_WIDTH-1:0] now;
      int unsigned            hi;
      int unsigned            per;
      bit                     rise;
      bit                     fall;
      now  = tick_now;
      rise = !last_level && level;
      fall = last_level && !level;
      got  = 1'b0;
      m    = '0;
      case (meter_phase)
         PH_WAIT_FALL: begin
            if (fall) begin
               fall_at     = now;
               meter_phase = PH_WAIT_SECOND;
            end
         end
         PH_WAIT_SECOND: begin
            if (rise) begin
               got = 1'b1;
               if (rise_stamp < fall_at && fall_at < now) begin
                  hi       = fall_at - rise_stamp;
                  per      = now - rise_stamp;
                  m.ok     = 1'b1;
                  m.high   = TICKS_WIDTH'(hi);
                  m.period = TICKS_WIDTH'(per);
                  m.duty   = DUTY_WIDTH'((hi * 100) / per);
                  m.freq   = FREQ_WIDTH'(rate_hz / per);
               end
               meter_phase = PH_WAIT_RISE;
            end
         end
         default: begin
            // An unused phase code behaves like waiting for the first rise.
            if (rise) begin
               rise_stamp  = now;
               meter_phase = PH_WAIT_FALL;
            end else begin
               meter_phase = PH_WAIT_RISE;
            end
         end
      endcase
      last_level = level;
      tick_now   = now + 1'b1;
   endtask

   // Offers one sample and returns at the edge where the transaction is
   // taken. The valid stays high when the next sample follows without a
   // gap, so it is never lowered and raised within one time step.
   task automatic send_sample(input logic level, input bit fixed = 1'b0,
                              input meas_type fixed_meas = '0);
      int       gap;
      bit       got;
      meas_type m;
      gap = req_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_WIDTH-1){1'b0}}, level};
      do @(posedge clock); while (req_tready !== 1'b1);
      step_meter(level, got, m);
      if (got) pending_meas.push_back(fixed ? fixed_meas : m);
   endtask

   task automatic add_row(input logic level, input bit fixed = 1'b0,
                          input meas_type want = '0);
      pulse_row_type row;
      row.level = level;
      row.fixed = fixed;
      row.want  = want;
      pulse_rows.push_back(row);
   endtask

   // The tick rate may change only while the block is quiet: every owed
   // measurement has arrived and the divider has had time to settle.
   task automatic wait_quiet();
      while (pending_meas.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_rate(input logic [RATE_WIDTH-1:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      rate_hz = value;
   endtask

   // A random phase is mostly a pulse train with runs of random length,
   // short runs being the most common, mixed with bursts of level noise.
   task automatic random_phase(input logic [RATE_WIDTH-1:0] rate, input int n_items);
      int   sent;
      int   run;
      int   pick;
      logic lvl;
      wait_quiet();
      write_rate(rate);
      sent = 0;
      lvl  = last_level;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            lvl  = ~lvl;
            pick = $urandom_range(0, 9);
            if (pick < 5)      run = $urandom_range(1, 3);
            else if (pick < 9) run = $urandom_range(4, 20);
            else               run = $urandom_range(21, 150);
            repeat (run) send_sample(lvl);
            sent += run;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               lvl = $urandom_range(0, 1);
               send_sample(lvl);
               sent++;
            end
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic check_field(input string what, input longint unsigned want,
                              input longint unsigned seen);
      if (want != seen) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, seen);
         errors++;
      end
   endtask

   // Result side: stalls a random number of cycles before each transaction,
   // then compares what arrives against the oldest owed measurement.
   initial begin : rsp_side
      int       stall;
      meas_type want;
      wait (reset === 1'b0);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (pending_meas.size() == 0) begin
            $display("%0t: unexpected measurement, expected none, actual tuser %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = pending_meas.pop_front();
            check_field("valid_res", want.ok, rsp_tuser);
            check_field("high_ticks", want.high, rsp_tdata[TICKS_WIDTH-1:0]);
            check_field("period_ticks", want.period,
                        rsp_tdata[2*TICKS_WIDTH-1:TICKS_WIDTH]);
            check_field("duty_percent", want.duty,
                        rsp_tdata[2*TICKS_WIDTH+DUTY_WIDTH-1:2*TICKS_WIDTH]);
            check_field("frequency_hz", want.freq,
                        rsp_tdata[2*TICKS_WIDTH+DUTY_WIDTH+FREQ_WIDTH-1:
                                  2*TICKS_WIDTH+DUTY_WIDTH]);
            check_field("tdata padding", 0,
                        rsp_tdata[RSP_DATA_WIDTH-1 -: RSP_PAD_WIDTH]);
         end
      end
   end

   // Safety net: a correct run takes well under a fifth of this time.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int waited;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_wdata  = '0;

      tick_now    = '0;
      last_level  = 1'b1;
      meter_phase = PH_WAIT_RISE;
      rise_stamp  = '0;
      fall_at     = '0;
      rate_hz     = RATE_RESET;

      // Directed pulse train, row n being tick n after reset. The signal
      // starts high, which must not count as a rising edge, and the first
      // fall is ignored as well. The first measurement is high 1 of period 3.
      add_row(1'b1);
      add_row(1'b0);
      add_row(1'b1);
      add_row(1'b0);
      add_row(1'b0);
      add_row(1'b1, 1'b1, {1'b1, 16'd1, 16'd3, 7'd33, 23'd333333});
      // The rise that closed the sequence does not open the next one, so
      // this fall is ignored. Then the shortest period there is: 2 ticks.
      add_row(1'b0);
      add_row(1'b1);
      add_row(1'b0);
      add_row(1'b1, 1'b1, {1'b1, 16'd1, 16'd2, 7'd50, 23'd500000});
      // A long high with a single low tick, duty close to the top.
      add_row(1'b0);
      repeat (7) add_row(1'b1);
      add_row(1'b0);
      add_row(1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (pulse_rows[i])
         send_sample(pulse_rows[i].level, pulse_rows[i].fixed, pulse_rows[i].want);
      req_tvalid <= 1'b0;

      // Random phases over several tick rates, 1 and 16000000 among them.
      // The first runs flat out on both sides so the measurement queue
      // fills and the sample side sees backpressure.
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      random_phase(24'd16000000, 280);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      random_phase(24'd1, 280);
      rsp_idle = 1'b0;
      random_phase(RATE_WIDTH'($urandom_range(1, 16000000)), 280);
      req_idle = 1'b0;
      rsp_idle = 1'b1;
      random_phase(RATE_WIDTH'($urandom_range(1, 16000000)), 280);
      req_idle = 1'b1;
      random_phase(RATE_RESET, 280);

      waited = 0;
      while (pending_meas.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (64) @(posedge clock);
      if (pending_meas.size() != 0) begin
         $display("%0t: measurements never arrived, expected 0 left, actual %0d",
                  $time, pending_meas.size());
         errors++;
      end
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
